@@ src/ipt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_pkg
// shared types and constants of the inverted page table with round-robin tlb
// ----------------------------------------------------------------------------
package ipt_pkg;

	localparam int FRAME_IDX_W = 5;
	localparam int SLOT_IDX_W  = 2;
	localparam int CMD_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_MARK   = 2'd2,
		CMD_FLUSH  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                   ld_en;
		logic                   ld_ro;
		logic [FRAME_IDX_W-1:0] ld_idx;
		logic                   wb_en;
		logic                   wb_dirty;
	} frame_ctl_t;

	typedef struct packed {
		logic                  fill_en;
		logic                  fill_dirty;
		logic                  mark_en;
		logic [SLOT_IDX_W-1:0] mark_idx;
		logic                  flush;
	} tlb_ctl_t;

	typedef struct packed {
		logic valid;
		logic found;
		logic dirty;
		logic ro;
	} token_t;

endpackage
`default_nettype wire

@@ src/ipt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_cell
// one frame entry of the inverted table; passes the search token on each cycle
// ----------------------------------------------------------------------------
module ipt_cell #(
	parameter int VPN_BITS   = 12,
	parameter int SPACE_BITS = 4,
	parameter int FI         = 5,
	parameter int INDEX      = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ipt_pkg::frame_ctl_t     ctl,
	input  wire  [VPN_BITS-1:0]     wr_vpn,
	input  wire  [SPACE_BITS-1:0]   wr_space,
	input  wire  [FI-1:0]           wb_frame,
	input  wire  [VPN_BITS-1:0]     req_vpn,
	input  wire  [SPACE_BITS-1:0]   req_space,
	input  ipt_pkg::token_t         tok_in,
	input  wire  [FI-1:0]           tok_frame_in,
	output ipt_pkg::token_t         tok_out,
	output logic [FI-1:0]           tok_frame_out
);
	import ipt_pkg::*;

	logic [VPN_BITS-1:0]   vpn_q;
	logic [SPACE_BITS-1:0] space_q;
	logic                  valid_q;
	logic                  dirty_q;
	logic                  ro_q;
	token_t                tok_q;
	logic [FI-1:0]         tok_frame_q;
	logic                  match;
	logic                  take;

	assign match = valid_q && (vpn_q == req_vpn) && (space_q == req_space);
	assign take  = tok_in.valid && !tok_in.found && match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpn_q   <= '0;
			space_q <= '0;
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			ro_q    <= 1'b0;
		end else if (ctl.ld_en && (32'(ctl.ld_idx) == INDEX)) begin
			vpn_q   <= wr_vpn;
			space_q <= wr_space;
			valid_q <= 1'b1;
			dirty_q <= 1'b0;
			ro_q    <= ctl.ld_ro;
		end else if (ctl.wb_en && (wb_frame == FI'(INDEX))) begin
			dirty_q <= ctl.wb_dirty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found | take;
			tok_q.dirty <= take ? dirty_q : tok_in.dirty;
			tok_q.ro    <= take ? ro_q : tok_in.ro;
		end
	end

	always_ff @(posedge clk) begin
		tok_frame_q <= take ? FI'(INDEX) : tok_frame_in;
	end

	assign tok_out       = tok_q;
	assign tok_frame_out = tok_frame_q;

endmodule
`default_nettype wire

@@ src/ipt_tlb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipt_tlb
// tlb slots with round-robin replacement pointer and eviction read-out
// ----------------------------------------------------------------------------
module ipt_tlb #(
	parameter int TLB_SLOTS = 4,
	parameter int FI        = 5,
	parameter int SI        = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ipt_pkg::tlb_ctl_t   ctl,
	input  wire  [FI-1:0]       fill_frame,
	output logic [SI-1:0]       next_slot,
	output logic                evict_valid,
	output logic                evict_dirty,
	output logic [FI-1:0]       evict_frame
);
	import ipt_pkg::*;

	logic [TLB_SLOTS-1:0] valid_q;
	logic [TLB_SLOTS-1:0] dirty_q;
	logic [FI-1:0]        frame_q [TLB_SLOTS];
	logic [SI-1:0]        ptr_q;

	assign next_slot   = (ptr_q == SI'(TLB_SLOTS - 1)) ? '0 : ptr_q + 1'b1;
	assign evict_valid = valid_q[next_slot];
	assign evict_dirty = dirty_q[next_slot];
	assign evict_frame = frame_q[next_slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (ctl.fill_en) begin
				ptr_q <= next_slot;
			end
			for (int i = 0; i < TLB_SLOTS; i++) begin
				if (ctl.flush) begin
					valid_q[i] <= 1'b0;
				end else if (ctl.fill_en && (next_slot == SI'(i))) begin
					valid_q[i] <= 1'b1;
				end
				if (ctl.mark_en && (32'(ctl.mark_idx) == i)) begin
					dirty_q[i] <= 1'b1;
				end else if (ctl.fill_en && (next_slot == SI'(i))) begin
					dirty_q[i] <= ctl.fill_dirty;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_SLOTS; i++) begin
				frame_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < TLB_SLOTS; i++) begin
				if (ctl.fill_en && (next_slot == SI'(i))) begin
					frame_q[i] <= fill_frame;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ src/inverted_page_table_tlb_refill.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// inverted_page_table_tlb_refill
// inverted page table as a chain of frame cells, with a round-robin tlb
// ----------------------------------------------------------------------------
// lookup: the search token starts from start_q, walks the chain of frame
//   cells one cell per cycle and is captured in ST_SCAN; ST_FINISH registers
//   the result once the output is free
// load, mark and flush: go straight to ST_FINISH, which registers the result
// one request at a time, taken in ST_IDLE after the result is registered
// reset clears the whole table, the tlb and the replacement pointer at once
// ----------------------------------------------------------------------------
module inverted_page_table_tlb_refill #(
	parameter int FRAMES     = 32,
	parameter int TLB_SLOTS  = 4,
	parameter int VPN_BITS   = 12,
	parameter int SPACE_BITS = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [1:0] command,
	input  wire  [11:0] virtual_page,
	input  wire  [3:0] space_id,
	input  wire  [4:0] frame_index,
	input  wire        read_only,
	input  wire  [1:0] slot_index,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       hit,
	output logic [4:0] frame,
	output logic [1:0] slot_filled,
	output logic       entry_read_only,
	output logic       entry_dirty
);
	import ipt_pkg::*;

	localparam int FI  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int SI  = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
	localparam int VW  = (VPN_BITS > 12) ? VPN_BITS : 12;
	localparam int SW  = (SPACE_BITS > 4) ? SPACE_BITS : 4;
	localparam int FOW = (FI > FRAME_IDX_W) ? FI : FRAME_IDX_W;
	localparam int SOW = (SI > SLOT_IDX_W) ? SI : SLOT_IDX_W;

	state_t                state_q, state_d;
	cmd_t                  cmd_q;
	logic [VPN_BITS-1:0]   vpn_q;
	logic [SPACE_BITS-1:0] space_q;
	logic [4:0]            fidx_q;
	logic                  ro_q;
	logic [1:0]            sidx_q;
	logic                  start_q;
	logic                  found_q;
	logic [FI-1:0]         hit_frame_q;
	logic                  hit_dirty_q;
	logic                  hit_ro_q;

	logic                  out_valid_q;
	logic                  hit_q;
	logic [4:0]            frame_q;
	logic [1:0]            slot_q;
	logic                  ro_out_q;
	logic                  dirty_out_q;

	logic [VW-1:0]         vpn_ext;
	logic [SW-1:0]         space_ext;
	logic                  accept;
	logic                  go;
	logic                  fill_dirty;
	frame_ctl_t            fctl;
	tlb_ctl_t              tctl;
	logic [SI-1:0]         next_slot;
	logic                  evict_valid;
	logic                  evict_dirty;
	logic [FI-1:0]         evict_frame;
	logic [FOW-1:0]        frame_wide;
	logic [SOW-1:0]        slot_wide;

	token_t                tok       [FRAMES+1];
	logic [FI-1:0]         tok_frame [FRAMES+1];
	logic [FRAMES-1:0]     tok_live;

	assign vpn_ext   = VW'(virtual_page);
	assign space_ext = SW'(space_id);
	assign accept    = in_valid && !in_stall;

	assign tok[0]       = '{valid: start_q, found: 1'b0, dirty: 1'b0, ro: 1'b0};
	assign tok_frame[0] = '0;

	genvar g;
	generate
		for (g = 0; g < FRAMES; g++) begin : g_cell
			ipt_cell #(
				.VPN_BITS  (VPN_BITS),
				.SPACE_BITS(SPACE_BITS),
				.FI        (FI),
				.INDEX     (g)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (fctl),
				.wr_vpn       (vpn_q),
				.wr_space     (space_q),
				.wb_frame     (evict_frame),
				.req_vpn      (vpn_q),
				.req_space    (space_q),
				.tok_in       (tok[g]),
				.tok_frame_in (tok_frame[g]),
				.tok_out      (tok[g+1]),
				.tok_frame_out(tok_frame[g+1])
			);
			assign tok_live[g] = tok[g+1].valid;
		end
	endgenerate

	ipt_tlb #(
		.TLB_SLOTS(TLB_SLOTS),
		.FI       (FI),
		.SI       (SI)
	) u_tlb (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tctl),
		.fill_frame (hit_frame_q),
		.next_slot  (next_slot),
		.evict_valid(evict_valid),
		.evict_dirty(evict_dirty),
		.evict_frame(evict_frame)
	);

	// write-back comes first, so an eviction of the matched frame carries over
	assign fill_dirty = (evict_valid && (evict_frame == hit_frame_q)) ? evict_dirty
	                                                                    : hit_dirty_q;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		go       = 1'b0;
		fctl     = '0;
		tctl     = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (cmd_t'(command) == CMD_LOOKUP) ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (tok[FRAMES].valid) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					go      = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		fctl.ld_en     = go && (cmd_q == CMD_LOAD);
		fctl.ld_ro     = ro_q;
		fctl.ld_idx    = fidx_q;
		fctl.wb_en     = go && (cmd_q == CMD_LOOKUP) && found_q && evict_valid;
		fctl.wb_dirty  = evict_dirty;
		tctl.fill_en    = go && (cmd_q == CMD_LOOKUP) && found_q;
		tctl.fill_dirty = fill_dirty;
		tctl.mark_en    = go && (cmd_q == CMD_MARK);
		tctl.mark_idx   = sidx_q;
		tctl.flush      = go && (cmd_q == CMD_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && (cmd_t'(command) == CMD_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(command);
			vpn_q   <= vpn_ext[VPN_BITS-1:0];
			space_q <= space_ext[SPACE_BITS-1:0];
			fidx_q  <= frame_index;
			ro_q    <= read_only;
			sidx_q  <= slot_index;
			found_q <= 1'b0;
		end else if (state_q == ST_SCAN && tok[FRAMES].valid) begin
			found_q     <= tok[FRAMES].found;
			hit_frame_q <= tok_frame[FRAMES];
			hit_dirty_q <= tok[FRAMES].dirty;
			hit_ro_q    <= tok[FRAMES].ro;
		end
	end

	assign frame_wide = FOW'(hit_frame_q);
	assign slot_wide  = SOW'(next_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (cmd_q == CMD_LOOKUP && found_q) begin
				hit_q       <= 1'b1;
				frame_q     <= frame_wide[4:0];
				slot_q      <= slot_wide[1:0];
				ro_out_q    <= hit_ro_q;
				dirty_out_q <= fill_dirty;
			end else begin
				hit_q       <= 1'b0;
				frame_q     <= '0;
				slot_q      <= '0;
				ro_out_q    <= 1'b0;
				dirty_out_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign frame           = frame_q;
	assign slot_filled     = slot_q;
	assign entry_read_only = ro_out_q;
	assign entry_dirty     = dirty_out_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_live) <= 1)
		else $error("more than one search token in the chain");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[FRAMES].valid |-> state_q == ST_SCAN)
		else $error("search token left the chain outside a scan");

	a_wb_with_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fctl.wb_en |-> tctl.fill_en && !fctl.ld_en)
		else $error("write-back without a tlb refill");

	a_finish_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished request not presented");

endmodule
`default_nettype wire
